### hw/rtl/tssg_pkg.sv
// Shared types and codes for the triangle scanline span generator.
package tssg_pkg;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_STEP = 1'b1;

    localparam logic [1:0] JOB_BOT0 = 2'd0;
    localparam logic [1:0] JOB_BOT1 = 2'd1;
    localparam logic [1:0] JOB_TOP0 = 2'd2;
    localparam logic [1:0] JOB_TOP1 = 2'd3;

    typedef struct packed {
        logic       load;
        logic       mul;
        logic       mid_direct;
        logic       start_mid;
        logic       wr_mid;
        logic       start_slope;
        logic       wr_slope;
        logic [1:0] job;
        logic       init_bottom;
        logic       init_top;
        logic       adv_bottom;
        logic       adv_top;
        logic       emit;
        logic       emit_last;
    } tssg_cmd_t;

    typedef struct packed {
        logic flat_bottom;
        logic ay_eq_by;
        logic row_ge_by;
        logic top_last;
        logic div_done;
        logic div_busy;
        logic out_busy;
    } tssg_status_t;

endpackage

### hw/rtl/tssg_div.sv
// Iterative signed divider, one quotient bit per cycle, truncates toward zero.
module tssg_div
    import tssg_pkg::*;
#(
    parameter int NUM_W = 29,
    parameter int DEN_W = 13
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [NUM_W:0]   num,
    input  logic signed [DEN_W:0]   den,
    output logic                    busy,
    output logic                    done,
    output logic signed [NUM_W:0]   quo
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic                 busy_reg;
    logic                 busy_next;
    logic                 done_reg;
    logic                 done_next;
    logic [CNT_W-1:0]     cnt_reg;
    logic [CNT_W-1:0]     cnt_next;
    logic                 neg_reg;
    logic [NUM_W-1:0]     q_reg;
    logic [DEN_W-1:0]     rem_reg;
    logic [DEN_W-1:0]     den_reg;

    logic signed [NUM_W:0] num_abs;
    logic signed [DEN_W:0] den_abs;
    logic [DEN_W:0]        trial;
    logic                  ge;
    logic [DEN_W:0]        rem_sub;

    assign num_abs = num[NUM_W] ? -num : num;
    assign den_abs = den[DEN_W] ? -den : den;
    assign trial   = {rem_reg, q_reg[NUM_W-1]};
    assign ge      = trial >= {1'b0, den_reg};
    assign rem_sub = ge ? (trial - {1'b0, den_reg}) : trial;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        if (start)
        begin
            if (den == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                busy_next = 1'b1;
                cnt_next  = CNT_W'(NUM_W);
            end
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= num[NUM_W] ^ den[DEN_W];
            q_reg   <= (den == '0) ? '0 : num_abs[NUM_W-1:0];
            rem_reg <= '0;
            den_reg <= den_abs[DEN_W-1:0];
        end
        else if (busy_reg)
        begin
            q_reg   <= {q_reg[NUM_W-2:0], ge};
            rem_reg <= rem_sub[DEN_W-1:0];
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quo  = neg_reg ? -$signed({1'b0, q_reg}) : $signed({1'b0, q_reg});

endmodule

### hw/rtl/tssg_datapath.sv
// Datapath: vertex sort, split point, edge slopes, edge accumulators and output register.
module tssg_datapath
    import tssg_pkg::*;
#(
    parameter int COORD_BITS = 13,
    parameter int FRAC_BITS  = 16
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  tssg_cmd_t                             cmd,
    output tssg_status_t                          sts,
    input  logic [6*COORD_BITS+31:0]              load_data,
    input  logic                                  out_ready,
    output logic                                  out_valid,
    output logic [COORD_BITS-1:0]                 span_y,
    output logic [COORD_BITS-1:0]                 span_x_from,
    output logic [COORD_BITS-1:0]                 span_x_to,
    output logic                                  span_visible,
    output logic                                  span_last,
    output logic [31:0]                           span_color
);

    localparam int C     = COORD_BITS;
    localparam int F     = FRAC_BITS;
    localparam int NUM_W = (C + F > 2 * C) ? (C + F) : (2 * C);
    localparam int NS    = NUM_W + 1;
    localparam int ACC_W = C + F + 2;

    function automatic logic signed [ACC_W-1:0] to_fix(input logic signed [C-1:0] x);
        to_fix = ACC_W'(x) <<< F;
    endfunction

    function automatic logic [C-1:0] fix_to_x(input logic signed [ACC_W-1:0] a);
        logic signed [ACC_W-1:0] sh;
        logic                    rnd;
        sh       = a >>> F;
        rnd      = a[ACC_W-1] && (a[F-1:0] != '0);
        fix_to_x = C'(sh + ACC_W'(rnd));
    endfunction

    // sort by y with three compare-swaps; a tie never swaps a pair
    logic signed [C-1:0] in_x0, in_y0, in_x1, in_y1, in_x2, in_y2;
    logic signed [C-1:0] p0x, p0y, p1x, p1y;
    logic signed [C-1:0] q0x, q0y, q2x, q2y;
    logic signed [C-1:0] r1x, r1y, r2x, r2y;

    assign in_x0 = load_data[C-1:0];
    assign in_y0 = load_data[2*C-1:C];
    assign in_x1 = load_data[3*C-1:2*C];
    assign in_y1 = load_data[4*C-1:3*C];
    assign in_x2 = load_data[5*C-1:4*C];
    assign in_y2 = load_data[6*C-1:5*C];

    always_comb
    begin
        if (in_y0 > in_y1)
        begin
            p0x = in_x1; p0y = in_y1; p1x = in_x0; p1y = in_y0;
        end
        else
        begin
            p0x = in_x0; p0y = in_y0; p1x = in_x1; p1y = in_y1;
        end
        if (p0y > in_y2)
        begin
            q0x = in_x2; q0y = in_y2; q2x = p0x; q2y = p0y;
        end
        else
        begin
            q0x = p0x; q0y = p0y; q2x = in_x2; q2y = in_y2;
        end
        if (p1y > q2y)
        begin
            r1x = q2x; r1y = q2y; r2x = p1x; r2y = p1y;
        end
        else
        begin
            r1x = p1x; r1y = p1y; r2x = q2x; r2y = q2y;
        end
    end

    logic signed [C-1:0]     ax_reg, ay_reg, bx_reg, by_reg, cx_reg, cy_reg;
    logic signed [C-1:0]     mid_reg;
    logic [31:0]             color_reg;
    logic signed [NUM_W:0]   mul_reg;
    logic signed [ACC_W-1:0] sb0_reg, sb1_reg, st0_reg, st1_reg;
    logic signed [ACC_W-1:0] acc0_reg, acc1_reg;
    logic signed [C-1:0]     row_reg;

    logic signed [C:0]       d_bx_ax, d_mid_ax, d_cx_ax, d_cx_bx, d_cx_mid;
    logic signed [C:0]       d_by_ay, d_cy_by, d_cy_ay;
    logic signed [2*C+1:0]   prod;
    logic signed [C:0]       dx_sel;
    logic signed [C:0]       dy_sel;
    logic signed [NUM_W:0]   div_num;
    logic signed [C:0]       div_den;
    logic signed [NUM_W:0]   div_quo;
    logic                    div_busy;
    logic                    div_done;
    logic signed [C:0]       mid_sum;
    logic signed [C:0]       row_m1;
    logic signed [C:0]       by_ext;
    logic [C-1:0]            x0;
    logic [C-1:0]            x1;

    assign d_bx_ax  = {bx_reg[C-1], bx_reg} - {ax_reg[C-1], ax_reg};
    assign d_mid_ax = {mid_reg[C-1], mid_reg} - {ax_reg[C-1], ax_reg};
    assign d_cx_ax  = {cx_reg[C-1], cx_reg} - {ax_reg[C-1], ax_reg};
    assign d_cx_bx  = {cx_reg[C-1], cx_reg} - {bx_reg[C-1], bx_reg};
    assign d_cx_mid = {cx_reg[C-1], cx_reg} - {mid_reg[C-1], mid_reg};
    assign d_by_ay  = {by_reg[C-1], by_reg} - {ay_reg[C-1], ay_reg};
    assign d_cy_by  = {cy_reg[C-1], cy_reg} - {by_reg[C-1], by_reg};
    assign d_cy_ay  = {cy_reg[C-1], cy_reg} - {ay_reg[C-1], ay_reg};
    assign prod     = d_cx_ax * d_by_ay;

    always_comb
    begin
        unique case (cmd.job)
            JOB_BOT0:
            begin
                dx_sel = d_bx_ax;
                dy_sel = d_by_ay;
            end
            JOB_BOT1:
            begin
                dx_sel = d_mid_ax;
                dy_sel = d_by_ay;
            end
            JOB_TOP0:
            begin
                dx_sel = sts.ay_eq_by ? d_cx_ax : d_cx_bx;
                dy_sel = d_cy_by;
            end
            JOB_TOP1:
            begin
                dx_sel = d_cx_mid;
                dy_sel = d_cy_by;
            end
            default:
            begin
                dx_sel = d_bx_ax;
                dy_sel = d_by_ay;
            end
        endcase
    end

    assign div_num = cmd.start_mid ? mul_reg : (NS'(dx_sel) <<< F);
    assign div_den = cmd.start_mid ? d_cy_ay : dy_sel;

    tssg_div #(
        .NUM_W (NUM_W),
        .DEN_W (C)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.start_mid | cmd.start_slope),
        .num   (div_num),
        .den   (div_den),
        .busy  (div_busy),
        .done  (div_done),
        .quo   (div_quo)
    );

    assign mid_sum = {ax_reg[C-1], ax_reg} + div_quo[C:0];
    assign row_m1  = {row_reg[C-1], row_reg} - 1'b1;
    assign by_ext  = {by_reg[C-1], by_reg};
    assign x0      = fix_to_x(acc0_reg);
    assign x1      = fix_to_x(acc1_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            ax_reg    <= q0x;
            ay_reg    <= q0y;
            bx_reg    <= r1x;
            by_reg    <= r1y;
            cx_reg    <= r2x;
            cy_reg    <= r2y;
            color_reg <= load_data[6*C+31:6*C];
        end
        if (cmd.mul)
        begin
            mul_reg <= NS'(prod);
        end
        if (cmd.mid_direct)
        begin
            mid_reg <= sts.flat_bottom ? cx_reg : bx_reg;
        end
        else if (cmd.wr_mid)
        begin
            mid_reg <= mid_sum[C-1:0];
        end
        if (cmd.wr_slope)
        begin
            unique case (cmd.job)
                JOB_BOT0: sb0_reg <= ACC_W'(div_quo);
                JOB_BOT1: sb1_reg <= ACC_W'(div_quo);
                JOB_TOP0: st0_reg <= ACC_W'(div_quo);
                JOB_TOP1: st1_reg <= ACC_W'(div_quo);
                default:  sb0_reg <= ACC_W'(div_quo);
            endcase
        end
        if (cmd.init_top)
        begin
            acc0_reg <= to_fix(cx_reg);
            acc1_reg <= to_fix(cx_reg);
            row_reg  <= cy_reg;
        end
        else if (cmd.init_bottom)
        begin
            acc0_reg <= to_fix(ax_reg);
            acc1_reg <= to_fix(ax_reg);
            row_reg  <= ay_reg;
        end
        else if (cmd.adv_bottom)
        begin
            acc0_reg <= acc0_reg + sb0_reg;
            acc1_reg <= acc1_reg + sb1_reg;
            row_reg  <= row_reg + 1'b1;
        end
        else if (cmd.adv_top)
        begin
            acc0_reg <= acc0_reg - st0_reg;
            acc1_reg <= acc1_reg - st1_reg;
            row_reg  <= row_m1[C-1:0];
        end
    end

    // output register
    logic         out_valid_reg;
    logic [C-1:0] span_y_reg;
    logic [C-1:0] span_x_from_reg;
    logic [C-1:0] span_x_to_reg;
    logic         span_visible_reg;
    logic         span_last_reg;
    logic [31:0]  span_color_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            span_y_reg       <= row_reg;
            span_x_from_reg  <= x0;
            span_x_to_reg    <= x1;
            span_visible_reg <= (x0 != x1);
            span_last_reg    <= cmd.emit_last;
            span_color_reg   <= color_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign span_y       = span_y_reg;
    assign span_x_from  = span_x_from_reg;
    assign span_x_to    = span_x_to_reg;
    assign span_visible = span_visible_reg;
    assign span_last    = span_last_reg;
    assign span_color   = span_color_reg;

    assign sts.flat_bottom = (by_reg == cy_reg);
    assign sts.ay_eq_by    = (ay_reg == by_reg);
    assign sts.row_ge_by   = (row_reg >= by_reg);
    assign sts.top_last    = (row_m1 <= by_ext);
    assign sts.div_done    = div_done;
    assign sts.div_busy    = div_busy;
    assign sts.out_busy    = out_valid_reg & ~out_ready;

endmodule

### hw/rtl/tssg_ctrl.sv
// Controller: triangle setup sequence and span phase state machine.
module tssg_ctrl
    import tssg_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    input  logic         in_command,
    output logic         in_ready,
    input  tssg_status_t sts,
    output tssg_cmd_t    cmd
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_SETUP    = 3'd1;
    localparam logic [2:0] S_MID_GO   = 3'd2;
    localparam logic [2:0] S_MID_WAIT = 3'd3;
    localparam logic [2:0] S_SLP_GO   = 3'd4;
    localparam logic [2:0] S_SLP_WAIT = 3'd5;
    localparam logic [2:0] S_BOTTOM   = 3'd6;
    localparam logic [2:0] S_TOP      = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic [1:0] job_reg;
    logic [1:0] job_next;
    logic       open_state;
    logic       accept;

    assign open_state = (state_reg == S_IDLE) || (state_reg == S_BOTTOM)
                        || (state_reg == S_TOP);
    assign in_ready   = open_state & ~sts.out_busy;
    assign accept     = in_valid & in_ready;

    always_comb
    begin
        state_next = state_reg;
        job_next   = job_reg;
        cmd        = '0;
        cmd.job    = job_reg;
        if (accept && in_command == CMD_LOAD)
        begin
            cmd.load   = 1'b1;
            state_next = S_SETUP;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                end
                S_SETUP:
                begin
                    cmd.mul  = 1'b1;
                    job_next = JOB_BOT0;
                    if (sts.flat_bottom || sts.ay_eq_by)
                    begin
                        cmd.mid_direct = 1'b1;
                        state_next     = S_SLP_GO;
                    end
                    else
                    begin
                        state_next = S_MID_GO;
                    end
                end
                S_MID_GO:
                begin
                    cmd.start_mid = 1'b1;
                    state_next    = S_MID_WAIT;
                end
                S_MID_WAIT:
                begin
                    if (sts.div_done)
                    begin
                        cmd.wr_mid = 1'b1;
                        state_next = S_SLP_GO;
                    end
                end
                S_SLP_GO:
                begin
                    cmd.start_slope = 1'b1;
                    state_next      = S_SLP_WAIT;
                end
                S_SLP_WAIT:
                begin
                    if (sts.div_done)
                    begin
                        cmd.wr_slope = 1'b1;
                        if (job_reg == JOB_TOP1)
                        begin
                            if (sts.ay_eq_by && !sts.flat_bottom)
                            begin
                                cmd.init_top = 1'b1;
                                state_next   = S_TOP;
                            end
                            else
                            begin
                                cmd.init_bottom = 1'b1;
                                state_next      = S_BOTTOM;
                            end
                        end
                        else
                        begin
                            job_next   = job_reg + 1'b1;
                            state_next = S_SLP_GO;
                        end
                    end
                end
                S_BOTTOM:
                begin
                    if (accept)
                    begin
                        cmd.emit = 1'b1;
                        if (sts.row_ge_by)
                        begin
                            if (sts.flat_bottom)
                            begin
                                cmd.emit_last = 1'b1;
                                state_next    = S_IDLE;
                            end
                            else
                            begin
                                cmd.init_top = 1'b1;
                                state_next   = S_TOP;
                            end
                        end
                        else
                        begin
                            cmd.adv_bottom = 1'b1;
                        end
                    end
                end
                S_TOP:
                begin
                    if (accept)
                    begin
                        cmd.emit      = 1'b1;
                        cmd.adv_top   = 1'b1;
                        cmd.emit_last = sts.top_last;
                        if (sts.top_last)
                        begin
                            state_next = S_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_next = S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            job_reg   <= JOB_BOT0;
        end
        else
        begin
            state_reg <= state_next;
            job_reg   <= job_next;
        end
    end

endmodule

### hw/rtl/triangle_scanline_span_generator_core.sv
// Top level of the triangle scanline span generator.
// Load transfer: input closed during setup (optional split-point and four slope divisions),
// N = max(COORD_BITS+FRAC_BITS, 2*COORD_BITS) bits, shared one-bit-per-cycle divider.
// Steps: one per cycle unless output stalls; span appears in output register next cycle.
// Zero-height edges give a zero divisor: the divider sets done without iterating, quotient 0.
// Reset (rst_n low, asynchronous): no triangle held, output empty, steps ignored.
module triangle_scanline_span_generator_core
    import tssg_pkg::*;
#(
    parameter int COORD_BITS = 13,
    parameter int FRAC_BITS  = 16
)
(
    input  logic                                           clk,
    input  logic                                           rst_n,
    input  logic                                           s_axis_tvalid,
    output logic                                           s_axis_tready,
    // vert0_x, vert0_y, vert1_x, vert1_y, vert2_x, vert2_y, fill_color, zero pad
    input  logic [((6*COORD_BITS+32+7)/8)*8-1:0]           s_axis_tdata,
    // command
    input  logic                                           s_axis_tuser,
    output logic                                           m_axis_tvalid,
    input  logic                                           m_axis_tready,
    // span_y, span_x_from, span_x_to, span_color, zero pad
    output logic [((3*COORD_BITS+32+7)/8)*8-1:0]           m_axis_tdata,
    // span_visible
    output logic                                           m_axis_tuser,
    output logic                                           m_axis_tlast
);

    localparam int OUT_W = ((3*COORD_BITS+32+7)/8)*8;

    tssg_cmd_t             cmd;
    tssg_status_t          sts;
    logic [COORD_BITS-1:0] span_y;
    logic [COORD_BITS-1:0] span_x_from;
    logic [COORD_BITS-1:0] span_x_to;
    logic [31:0]           span_color;

    tssg_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_command (s_axis_tuser),
        .in_ready   (s_axis_tready),
        .sts        (sts),
        .cmd        (cmd)
    );

    tssg_datapath #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .load_data    (s_axis_tdata[6*COORD_BITS+31:0]),
        .out_ready    (m_axis_tready),
        .out_valid    (m_axis_tvalid),
        .span_y       (span_y),
        .span_x_from  (span_x_from),
        .span_x_to    (span_x_to),
        .span_visible (m_axis_tuser),
        .span_last    (m_axis_tlast),
        .span_color   (span_color)
    );

    assign m_axis_tdata = OUT_W'({span_color, span_x_to, span_x_from, span_y});

    a_no_accept_while_dividing: assert property (
        @(posedge clk) disable iff (!rst_n)
        sts.div_busy |-> !s_axis_tready)
        else $error("input accepted while divider busy");

    a_load_blocks_input: assert property (
        @(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tuser == CMD_LOAD) |=> !s_axis_tready)
        else $error("input open directly after load transfer");

    a_span_from_step: assert property (
        @(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |->
            $past(s_axis_tvalid && s_axis_tready && s_axis_tuser == CMD_STEP))
        else $error("span produced without step transfer");

    a_emit_not_in_setup: assert property (
        @(posedge clk) disable iff (!rst_n)
        cmd.emit |-> !sts.div_busy && !sts.div_done)
        else $error("span emitted during triangle setup");

endmodule

### tb/tssg_span_checker.sv
// Span checker: predicts each span from the accepted transfers and compares the output stream.
module tssg_span_checker
    import tssg_pkg::*;
#(
    parameter int COORD_BITS = 13,
    parameter int FRAC_BITS  = 16
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    input  logic                                 s_tready,
    input  logic [((6*COORD_BITS+32+7)/8)*8-1:0] s_tdata,
    input  logic                                 s_tuser,
    input  logic                                 m_tvalid,
    input  logic                                 m_tready,
    input  logic [((3*COORD_BITS+32+7)/8)*8-1:0] m_tdata,
    input  logic                                 m_tuser,
    input  logic                                 m_tlast,
    output int                                   errors,
    output int                                   pending
);

    localparam int IN_W = ((6*COORD_BITS+32+7)/8)*8;
    localparam longint UNIT = longint'(1) <<< FRAC_BITS;
    localparam int PRINT_CAP = 100;

    localparam logic [1:0] TRI_IDLE = 2'd0;
    localparam logic [1:0] TRI_DOWN = 2'd1;
    localparam logic [1:0] TRI_UP   = 2'd2;

    typedef struct packed {
        logic [COORD_BITS-1:0] y;
        logic [COORD_BITS-1:0] x_from;
        logic [COORD_BITS-1:0] x_to;
        logic                  visible;
        logic                  last;
        logic [31:0]           colour;
    } span_t;

    span_t       owed_spans[$];
    int          fail_count = 0;
    logic [1:0]  fill_phase = TRI_IDLE;
    longint      vx[3];
    longint      vy[3];
    longint      split_x;
    longint      scan_row = 0;
    longint      acc_l;
    longint      acc_r;
    longint      rate_l;
    longint      rate_r;
    logic [31:0] colour = '0;

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        fail_count++;
        if (fail_count <= PRINT_CAP)
            $display("span mismatch (%s): got %h, expected %h", what, got, want);
    endtask

    function automatic longint coord(input logic [IN_W-1:0] d, input int idx);
        return longint'($signed(d[idx*COORD_BITS +: COORD_BITS]));
    endfunction

    // zero height gives zero slope
    function automatic longint inv_slope(input longint dx, input longint dy);
        if (dy == 0)
            return 0;
        return (dx * UNIT) / dy;
    endfunction

    function automatic void begin_upper();
        if (vy[0] == vy[1])
        begin
            rate_l = inv_slope(vx[2] - vx[0], vy[2] - vy[0]);
            rate_r = inv_slope(vx[2] - vx[1], vy[2] - vy[1]);
        end
        else
        begin
            rate_l = inv_slope(vx[2] - vx[1], vy[2] - vy[1]);
            rate_r = inv_slope(vx[2] - split_x, vy[2] - vy[1]);
        end
        acc_l      = vx[2] * UNIT;
        acc_r      = vx[2] * UNIT;
        scan_row   = vy[2];
        fill_phase = TRI_UP;
    endfunction

    function automatic void load_triangle(input logic [IN_W-1:0] d);
        longint px[3];
        longint py[3];
        longint t;
        int     lo_idx[3];
        int     hi_idx[3];
        lo_idx = '{0, 0, 1};
        hi_idx = '{1, 2, 2};
        for (int i = 0; i < 3; i++)
        begin
            px[i] = coord(d, 2*i);
            py[i] = coord(d, 2*i + 1);
        end
        // three compare-swaps; a tie never swaps a pair
        for (int k = 0; k < 3; k++)
        begin
            if (py[lo_idx[k]] > py[hi_idx[k]])
            begin
                t = px[lo_idx[k]]; px[lo_idx[k]] = px[hi_idx[k]]; px[hi_idx[k]] = t;
                t = py[lo_idx[k]]; py[lo_idx[k]] = py[hi_idx[k]]; py[hi_idx[k]] = t;
            end
        end
        vx     = px;
        vy     = py;
        colour = d[6*COORD_BITS +: 32];
        if (vy[1] == vy[2])
            split_x = vx[2];
        else if (vy[0] == vy[1])
        begin
            split_x = vx[1];
            begin_upper();
            return;
        end
        else
            split_x = vx[0] + ((vx[2] - vx[0]) * (vy[1] - vy[0])) / (vy[2] - vy[0]);
        rate_l     = inv_slope(vx[1] - vx[0], vy[1] - vy[0]);
        rate_r     = inv_slope(split_x - vx[0], vy[1] - vy[0]);
        acc_l      = vx[0] * UNIT;
        acc_r      = vx[0] * UNIT;
        scan_row   = vy[0];
        fill_phase = TRI_DOWN;
    endfunction

    function automatic bit next_span(output span_t s);
        longint r;
        longint xl;
        longint xr;
        bit     fin;
        s = '0;
        if (fill_phase == TRI_IDLE)
            return 1'b0;
        r   = scan_row;
        xl  = acc_l / UNIT;
        xr  = acc_r / UNIT;
        fin = 1'b0;
        if (fill_phase == TRI_DOWN)
        begin
            if (r >= vy[1])
            begin
                fin = (vy[2] == vy[1]);
                if (fin)
                    fill_phase = TRI_IDLE;
                else
                    begin_upper();
            end
            else
            begin
                acc_l    += rate_l;
                acc_r    += rate_r;
                scan_row  = r + 1;
            end
        end
        else
        begin
            scan_row  = r - 1;
            acc_l    -= rate_l;
            acc_r    -= rate_r;
            fin       = (scan_row <= vy[1]);
            if (fin)
                fill_phase = TRI_IDLE;
        end
        s.y       = r[COORD_BITS-1:0];
        s.x_from  = xl[COORD_BITS-1:0];
        s.x_to    = xr[COORD_BITS-1:0];
        s.visible = (xl != xr);
        s.last    = fin;
        s.colour  = colour;
        return 1'b1;
    endfunction

    always @(posedge clk)
    begin
        span_t want;
        span_t made;
        if (!rst_n)
        begin
            fill_phase = TRI_IDLE;
            scan_row   = 0;
            colour     = '0;
            owed_spans.delete();
        end
        else
        begin
            // outputs first: a span never leaves in the cycle its step is taken
            if (m_tvalid && m_tready)
            begin
                if (owed_spans.size() == 0)
                    report("span with none owed", m_tdata[31:0], 32'd0);
                else
                begin
                    want = owed_spans.pop_front();
                    if (m_tdata[0 +: COORD_BITS] !== want.y)
                        report("span_y", m_tdata[0 +: COORD_BITS], want.y);
                    if (m_tdata[COORD_BITS +: COORD_BITS] !== want.x_from)
                        report("span_x_from", m_tdata[COORD_BITS +: COORD_BITS], want.x_from);
                    if (m_tdata[2*COORD_BITS +: COORD_BITS] !== want.x_to)
                        report("span_x_to", m_tdata[2*COORD_BITS +: COORD_BITS], want.x_to);
                    if (m_tdata[3*COORD_BITS +: 32] !== want.colour)
                        report("span_color", m_tdata[3*COORD_BITS +: 32], want.colour);
                    if (m_tuser !== want.visible)
                        report("span_visible", m_tuser, want.visible);
                    if (m_tlast !== want.last)
                        report("span_last", m_tlast, want.last);
                end
            end
            if (s_tvalid && s_tready)
            begin
                if (s_tuser == CMD_LOAD)
                    load_triangle(s_tdata);
                else if (next_span(made))
                    owed_spans.push_back(made);
            end
        end
        errors  <= fail_count;
        pending <= owed_spans.size();
    end

endmodule

### tb/triangle_scanline_span_generator_core_tb.sv
// Testbench top: drives loads and span steps into the core and gives the verdict.
module triangle_scanline_span_generator_core_tb
    import tssg_pkg::*;
();

    localparam int     COORD_BITS  = 13;
    localparam int     FRAC_BITS   = 16;
    localparam int     IN_W        = ((6*COORD_BITS+32+7)/8)*8;
    localparam int     OUT_W       = ((3*COORD_BITS+32+7)/8)*8;
    localparam int     CYCLE_LIMIT = 1000000;
    localparam int     ITEM_TARGET = 650;
    localparam longint C_MIN       = -(longint'(1) <<< (COORD_BITS-1));
    localparam longint C_MAX       = (longint'(1) <<< (COORD_BITS-1)) - 1;

    logic             clk           = 1'b0;
    logic             rst_n         = 1'b0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [IN_W-1:0]  s_axis_tdata  = '0;
    logic             s_axis_tuser  = CMD_STEP;
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [OUT_W-1:0] m_axis_tdata;
    logic             m_axis_tuser;
    logic             m_axis_tlast;

    int fail_count;
    int spans_owed;
    int cycles      = 0;
    int burst_left  = 0;
    int sent        = 0;
    int stall_mode  = 0;
    int stall_tick  = 0;

    triangle_scanline_span_generator_core #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    tssg_span_checker #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_checker (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_axis_tvalid),
        .s_tready (s_axis_tready),
        .s_tdata  (s_axis_tdata),
        .s_tuser  (s_axis_tuser),
        .m_tvalid (m_axis_tvalid),
        .m_tready (m_axis_tready),
        .m_tdata  (m_axis_tdata),
        .m_tuser  (m_axis_tuser),
        .m_tlast  (m_axis_tlast),
        .errors   (fail_count),
        .pending  (spans_owed)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("[triangle_scanline_span_generator_core] ERROR");
            $finish;
        end
    end

    // receiver stall pattern; the mode is re-picked at random
    always @(posedge clk)
    begin
        if (stall_tick % 48 == 0)
            stall_mode = $urandom_range(0, 3);
        stall_tick++;
        case (stall_mode)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= 1'($urandom_range(0, 1));
            2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
            default: m_axis_tready <= stall_tick[3];
        endcase
    end

    function automatic longint clamp(input longint v);
        if (v < C_MIN)
            return C_MIN;
        if (v > C_MAX)
            return C_MAX;
        return v;
    endfunction

    function automatic longint rnd_coord();
        return longint'($urandom_range(0, (1 << COORD_BITS) - 1)) + C_MIN;
    endfunction

    function automatic logic [IN_W-1:0] pack_tri(input longint x0, input longint y0,
                                                 input longint x1, input longint y1,
                                                 input longint x2, input longint y2,
                                                 input logic [31:0] c);
        logic [COORD_BITS-1:0] f[6];
        logic [IN_W-1:0]       d;
        f[0] = x0[COORD_BITS-1:0];
        f[1] = y0[COORD_BITS-1:0];
        f[2] = x1[COORD_BITS-1:0];
        f[3] = y1[COORD_BITS-1:0];
        f[4] = x2[COORD_BITS-1:0];
        f[5] = y2[COORD_BITS-1:0];
        d = '0;
        for (int i = 0; i < 6; i++)
            d[i*COORD_BITS +: COORD_BITS] = f[i];
        d[6*COORD_BITS +: 32] = c;
        return d;
    endfunction

    // one transfer; bursts of random length with random gaps between them
    task automatic push(input logic cmd, input logic [IN_W-1:0] data);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= data;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        burst_left--;
        sent++;
    endtask

    task automatic load_tri(input longint x0, input longint y0, input longint x1,
                            input longint y1, input longint x2, input longint y2,
                            input logic [31:0] c);
        push(CMD_LOAD, pack_tri(x0, y0, x1, y1, x2, y2, c));
    endtask

    // step payload is ignored by the core, so it carries noise
    task automatic steps(input int n);
        repeat (n)
            push(CMD_STEP, pack_tri(rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(),
                                    rnd_coord(), rnd_coord(), $urandom()));
    endtask

    task automatic load_random();
        load_tri(rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(),
                 rnd_coord(), $urandom());
    endtask

    function automatic int span_count(input longint ya, input longint yb, input longint yc);
        longint lo;
        longint hi;
        longint mid;
        int     n;
        lo  = (ya < yb) ? ((ya < yc) ? ya : yc) : ((yb < yc) ? yb : yc);
        hi  = (ya > yb) ? ((ya > yc) ? ya : yc) : ((yb > yc) ? yb : yc);
        mid = ya + yb + yc - lo - hi;
        n   = int'(hi - lo + 1);
        // flat top never emits the shared row
        if (lo == mid && mid != hi)
            n--;
        return n;
    endfunction

    task automatic small_triangle();
        longint xs[3];
        longint ys[3];
        longint base_x;
        longint base_y;
        longint t;
        int     shape;
        int     n;
        int     j;
        base_x = rnd_coord();
        base_y = rnd_coord();
        shape  = $urandom_range(0, 7);
        for (int i = 0; i < 3; i++)
            xs[i] = clamp(base_x + longint'($urandom_range(0, 80)) - 40);
        ys[0] = base_y;
        ys[1] = base_y + $urandom_range(0, 12);
        ys[2] = base_y + $urandom_range(0, 12);
        case (shape)
            0:
            begin
                ys[1] = ys[0];
                ys[2] = ys[0] + $urandom_range(1, 12);
            end
            1:
            begin
                ys[1] = ys[0] + $urandom_range(1, 12);
                ys[2] = ys[1];
            end
            2:
            begin
                ys[1] = ys[0];
                ys[2] = ys[0];
            end
            default: ;
        endcase
        for (int i = 0; i < 3; i++)
            ys[i] = clamp(ys[i]);
        for (int i = 2; i > 0; i--)
        begin
            j = $urandom_range(0, i);
            t = xs[i]; xs[i] = xs[j]; xs[j] = t;
            t = ys[i]; ys[i] = ys[j]; ys[j] = t;
        end
        n = span_count(ys[0], ys[1], ys[2]);
        if ($urandom_range(0, 7) == 0)
            n = $urandom_range(1, n);
        else
            n += $urandom_range(0, 1);
        load_tri(xs[0], ys[0], xs[1], ys[1], xs[2], ys[2], $urandom());
        steps(n);
    endtask

    initial
    begin
        int pick;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // steps with nothing loaded
        steps(2);
        // full-range corners, cut short by the next load
        load_tri(C_MIN, C_MIN, C_MAX, C_MAX, C_MIN, C_MAX, 32'hFFFF_FFFF);
        steps(3);
        // flat bottom, one extra step after the last span
        load_tri(10, -3, 2, 2, 20, 2, 32'h0000_0000);
        steps(7);
        // flat top
        load_tri(0, 5, 8, 5, 4, 9, 32'hA5A5_5A5A);
        steps(4);
        // all rows equal at the top limit
        load_tri(C_MAX, C_MAX, C_MIN, C_MAX, 0, C_MAX, 32'h1234_5678);
        steps(2);
        // general case given out of order
        load_tri(3, 3, 0, 1, 5, 2, 32'h8000_0001);
        steps(3);

        while (sent < ITEM_TARGET)
        begin
            pick = $urandom_range(0, 19);
            if (pick == 0)
            begin
                repeat ($urandom_range(1, 3))
                begin
                    if ($urandom_range(0, 1))
                        steps(1);
                    else
                        load_random();
                end
            end
            else if (pick <= 2)
            begin
                load_random();
                steps($urandom_range(1, 30));
            end
            else
                small_triangle();
        end

        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (spans_owed != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("[triangle_scanline_span_generator_core] OK");
        else
            $display("[triangle_scanline_span_generator_core] ERROR");
        $finish;
    end

endmodule
